>>> rtl/rfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the range frame checker.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam logic [7:0]  HEADER_BYTE      = 8'h54;
    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [7:0]  CRC_INIT         = 8'h00;
    localparam logic [15:0] RAW_OUT_OF_RANGE = 16'hFFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_RAW = 1'b0,
        REG_MAX_RAW = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_TOO_CLOSE = 2'd1,
        ST_OUT_RANGE = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] range_value;
        t_status     status;
    } t_result;

    // MSB-first CRC-8, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/rfc_in_stage.sv
// Input register stage: captures one received byte per handshake.
`timescale 1ns / 1ps

module rfc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    input  logic       i_take,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> rtl/rfc_parser.sv
// Frame parser: header sync, CRC-8 accumulation, range capture and status decision.
`timescale 1ns / 1ps

module rfc_parser #(
    parameter int FRAME_LEN = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [rfc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_step,
    input  logic [7:0]                       i_byte,
    output logic                             o_res_valid,
    output rfc_pkg::t_result                 o_res
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [15:0]      r_min_raw;
    logic [15:0]      r_max_raw;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    logic [7:0]       r_range_hi;
    logic [7:0]       n_range_hi;
    logic [7:0]       r_range_lo;
    logic [7:0]       n_range_lo;
    logic [7:0]       crc_step;
    logic [15:0]      raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw <= 16'h0000;
            r_max_raw <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (rfc_pkg::t_cfg_idx'(i_cfg_addr))
                rfc_pkg::REG_MIN_RAW: r_min_raw <= i_cfg_wdata;
                rfc_pkg::REG_MAX_RAW: r_max_raw <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign crc_step = rfc_pkg::crc8_byte(r_crc, i_byte);
    assign raw      = {r_range_hi, r_range_lo};

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_range_hi  = r_range_hi;
        n_range_lo  = r_range_lo;
        o_res_valid = 1'b0;
        if (i_step) begin
            if (r_pos == '0) begin
                if (i_byte == rfc_pkg::HEADER_BYTE) begin
                    n_crc = rfc_pkg::crc8_byte(rfc_pkg::CRC_INIT, i_byte);
                    n_pos = POS_W'(1);
                end
            end else if (r_pos < LAST_POS) begin
                n_crc = crc_step;
                if (r_pos == POS_W'(1)) begin
                    n_range_hi = i_byte;
                end else if (r_pos == POS_W'(2)) begin
                    n_range_lo = i_byte;
                end
                n_pos = r_pos + POS_W'(1);
            end else begin
                o_res_valid = 1'b1;
                n_pos       = '0;
                n_crc       = rfc_pkg::CRC_INIT;
            end
        end
    end

    // first match wins
    always_comb begin
        o_res.range_value = raw;
        if (r_crc != i_byte) begin
            o_res.status = rfc_pkg::ST_CRC_ERR;
        end else if (raw == 16'h0000) begin
            o_res.status = rfc_pkg::ST_TOO_CLOSE;
        end else if (raw == rfc_pkg::RAW_OUT_OF_RANGE) begin
            o_res.status = rfc_pkg::ST_OUT_RANGE;
        end else if (raw > r_max_raw) begin
            o_res.status = rfc_pkg::ST_OUT_RANGE;
        end else if (raw < r_min_raw) begin
            o_res.status = rfc_pkg::ST_TOO_CLOSE;
        end else begin
            o_res.status = rfc_pkg::ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= rfc_pkg::CRC_INIT;
            r_range_hi <= 8'h00;
            r_range_lo <= 8'h00;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_range_hi <= n_range_hi;
            r_range_lo <= n_range_lo;
        end
    end

endmodule

>>> rtl/rfc_out_stage.sv
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module rfc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rfc_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output rfc_pkg::t_result o_res
);

    logic             r_valid;
    rfc_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/range_frame_checker_unit.sv
// Path: a frame's last byte is held in the input register, then the parser's
// status decision is captured in the result register that drives the output.
// Throughput: one byte per cycle; input register, parser and result register
// advance together, stalling only while the result register is held.
// Reset (synchronous, active low): receiver idle awaiting header, CRC cleared,
// min_raw 0, max_raw 0xFFFF, both pipeline registers empty.
`timescale 1ns / 1ps

module range_frame_checker_unit #(
    parameter int FRAME_LEN = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] rx_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata   // [15:0] range_value, [17:16] status
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_free;
    logic             res_valid;
    rfc_pkg::t_result res;
    rfc_pkg::t_result out_res;

    rfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .o_valid (in_valid),
        .i_take  (out_free),
        .o_byte  (in_byte)
    );

    rfc_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (in_valid && out_free),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {6'b000000, out_res.status, out_res.range_value};

endmodule

>>> dv/range_frame_checker_unit_test.sv
// Self-checking testbench for range_frame_checker_unit: header search, CRC-8 check and range status.
`timescale 1ns / 1ps

module range_frame_checker_unit_test;

    localparam int FRAME_LEN    = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_addr;
    logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [7:0]                     i_s_axis_tdata;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [23:0]                    o_m_axis_tdata;

    range_frame_checker_unit #(
        .FRAME_LEN(FRAME_LEN)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    int send_idle_pct = 15;
    int recv_idle_pct = 83;
    int mismatch_count = 0;
    int sent_items = 0;
    int idle_cycles = 0;

    // frame tracker state
    logic [4:0]  rx_pos = '0;
    logic [7:0]  rx_crc = rfc_pkg::CRC_INIT;
    logic [7:0]  range_hi = '0;
    logic [7:0]  range_lo = '0;
    logic [15:0] cfg_min_raw = 16'h0000;
    logic [15:0] cfg_max_raw = 16'hFFFF;

    rfc_pkg::t_result expected_readings[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bit-serial CRC-8, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? rfc_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        logic [15:0]      raw;
        rfc_pkg::t_result want;
        if (rx_pos == 0) begin
            if (b == rfc_pkg::HEADER_BYTE) begin
                rx_crc = crc8_next(rfc_pkg::CRC_INIT, b);
                rx_pos = 5'd1;
            end
        end else if (rx_pos < FRAME_LEN - 1) begin
            rx_crc = crc8_next(rx_crc, b);
            if (rx_pos == 1) begin
                range_hi = b;
            end else if (rx_pos == 2) begin
                range_lo = b;
            end
            rx_pos = rx_pos + 5'd1;
        end else begin
            raw = {range_hi, range_lo};
            want.range_value = raw;
            if (rx_crc != b) begin
                want.status = rfc_pkg::ST_CRC_ERR;
            end else if (raw == 16'h0000) begin
                want.status = rfc_pkg::ST_TOO_CLOSE;
            end else if (raw == rfc_pkg::RAW_OUT_OF_RANGE) begin
                want.status = rfc_pkg::ST_OUT_RANGE;
            end else if (raw > cfg_max_raw) begin
                want.status = rfc_pkg::ST_OUT_RANGE;
            end else if (raw < cfg_min_raw) begin
                want.status = rfc_pkg::ST_TOO_CLOSE;
            end else begin
                want.status = rfc_pkg::ST_VALID;
            end
            expected_readings.push_back(want);
            rx_pos = '0;
            rx_crc = rfc_pkg::CRC_INIT;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        absorb_byte(b);
        sent_items++;
    endtask

    task automatic send_frame(input logic [15:0] raw, input bit corrupt);
        logic [7:0] crc;
        crc = crc8_next(crc8_next(crc8_next(rfc_pkg::CRC_INIT, rfc_pkg::HEADER_BYTE),
                                  raw[15:8]), raw[7:0]);
        if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(rfc_pkg::HEADER_BYTE);
        send_byte(raw[15:8]);
        send_byte(raw[7:0]);
        send_byte(crc);
    endtask

    // finish any open frame, then let the pipeline empty
    task automatic wait_idle();
        while (rx_pos != 0) send_byte(8'($urandom_range(0, 255)));
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rfc_pkg::t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == rfc_pkg::REG_MIN_RAW) begin
            cfg_min_raw = val;
        end else begin
            cfg_max_raw = val;
        end
    endtask

    task automatic set_limits(input logic [15:0] lo_lim, input logic [15:0] hi_lim);
        wait_idle();
        write_reg(rfc_pkg::REG_MIN_RAW, lo_lim);
        write_reg(rfc_pkg::REG_MAX_RAW, hi_lim);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return rfc_pkg::RAW_OUT_OF_RANGE;
            2: return cfg_min_raw + 16'($urandom_range(0, 2)) - 16'd1;
            3: return cfg_max_raw + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_header_search_and_status();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'h0000, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'h1234, 1'b0);
        send_frame(16'h5454, 1'b1);  // header value as data, bad CRC
        send_frame(16'hFFFE, 1'b0);
    endtask

    task automatic probe_limits(input logic [15:0] lo_lim, input logic [15:0] hi_lim);
        set_limits(lo_lim, hi_lim);
        send_frame(lo_lim - 16'd1, 1'b0);
        send_frame(lo_lim, 1'b0);
        send_frame(hi_lim, 1'b0);
        send_frame(hi_lim + 16'd1, 1'b0);
        send_frame(16'($urandom), 1'b0);
    endtask

    task automatic test_threshold_settings();
        probe_limits(16'h1000, 16'h2000);
        probe_limits(16'hFFFF, 16'h0000);  // inverted
        probe_limits(16'h0000, 16'h0000);
        probe_limits(16'hFFFF, 16'hFFFF);
        probe_limits(16'h0000, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int n_items);
        int          target;
        int          pick;
        logic [15:0] a;
        logic [15:0] b;
        target = sent_items + n_items;
        while (sent_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_frame(pick_raw(), 1'b0);
            end else if (pick < 85) begin
                send_frame(pick_raw(), 1'b1);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // truncated frame
                send_byte(rfc_pkg::HEADER_BYTE);
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 39) == 0) begin
                a = 16'($urandom);
                b = 16'($urandom);
                if ((a > b) ^ ($urandom_range(0, 9) == 0)) begin
                    set_limits(b, a);
                end else begin
                    set_limits(a, b);
                end
            end
        end
    endtask

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_reading
        rfc_pkg::t_result got;
        rfc_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.range_value = o_m_axis_tdata[15:0];
            got.status      = rfc_pkg::t_status'(o_m_axis_tdata[17:16]);
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected reading: expected none, got range %h status %0d",
                         $time, got.range_value, got.status);
            end else begin
                want = expected_readings.pop_front();
                if (got.range_value != want.range_value) begin
                    mismatch_count++;
                    $display("%0t: range_value mismatch: expected %h, got %h",
                             $time, want.range_value, got.range_value);
                end
                if (got.status != want.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = rfc_pkg::REG_MIN_RAW;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 83;
        test_header_search_and_status();
        test_threshold_settings();
        test_random_traffic(130);

        send_idle_pct = 83;
        recv_idle_pct = 15;
        test_random_traffic(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(200);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
